// File: src/dpi_pkg.sv
// Package for the demand profile insert block: widths, status codes and sequencer states.
// No dependencies.
`default_nettype none
package dpi_pkg;
    localparam int CAPACITY_DEF    = 64;
    localparam int TIME_BITS_DEF   = 32;
    localparam int DEMAND_BITS_DEF = 16;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_COPY,
        S_RESULT
    } state_t;
endpackage
`default_nettype wire

// File: src/demand_profile_insert.sv
// Demand profile insert: sorted segment table with split-and-add insert of one task.
// Sequence: scan the stored segments into a work table, append the tail gap, then copy back;
// a task dropped as full skips the copy, and an empty span goes straight to the result.
// Throughput: one task per result; a new task is taken only after the result is delivered.
// Reset (aresetn low, synchronous) empties the table; entries are never read before written.
// Depends on dpi_pkg.
`default_nettype none
module demand_profile_insert #(
    parameter int CAPACITY    = dpi_pkg::CAPACITY_DEF,
    parameter int TIME_BITS   = dpi_pkg::TIME_BITS_DEF,
    parameter int DEMAND_BITS = dpi_pkg::DEMAND_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] task_start, [63:32] task_end, [79:64] task_demand
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [17:2] peak_demand, [24:18] segment_count, [31:25] zero
    output logic [31:0]      m_tdata
);
    import dpi_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WD = 2 * CAPACITY + 3;
    localparam int WW = $clog2(WD + 1);
    localparam int TB = TIME_BITS;
    localparam int DB = DEMAND_BITS;
    localparam logic [DB-1:0] DMAX = {DB{1'b1}};

    // table and work memories
    logic [TB-1:0] seg_s_mem [CAPACITY];
    logic [TB-1:0] seg_e_mem [CAPACITY];
    logic [DB-1:0] seg_d_mem [CAPACITY];
    logic [TB-1:0] wrk_s_mem [CAPACITY];
    logic [TB-1:0] wrk_e_mem [CAPACITY];
    logic [DB-1:0] wrk_d_mem [CAPACITY];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [DB-1:0] peak_reg, peak_acc_reg;
    logic [TB-1:0] ts_reg, te_reg, cur_reg;
    logic [DB-1:0] td_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] wa_reg;
    logic          phase_reg; // 0: issue read, 1: data valid
    logic [WW-1:0] wn_reg;
    logic [1:0]    status_reg;
    logic [TB-1:0] rs_reg, re_reg;
    logic [DB-1:0] rd_reg;
    // emission queue: up to three segments from one stored segment
    logic [2:0]    eq_v_reg;
    logic [TB-1:0] eq_s_reg [3];
    logic [TB-1:0] eq_e_reg [3];
    logic [DB-1:0] eq_d_reg [3];
    logic [1:0]    eq_k_reg;

    wire logic [TB-1:0] in_s = TB'(s_tdata[31:0]);
    wire logic [TB-1:0] in_e = TB'(s_tdata[63:32]);
    logic [DB-1:0] in_d;
    always_comb begin
        if (s_tdata[79:64] > 16'(DMAX)) in_d = DMAX;
        else                            in_d = DB'(s_tdata[79:64]);
    end

    wire logic in_acc  = s_tvalid && s_tready;
    wire logic out_acc = m_tvalid && m_tready;

    logic [DB:0] sum_w;
    assign sum_w = {1'b0, rd_reg} + {1'b0, td_reg};

    // classify the fetched segment against the task span
    logic disj_w, gap_w, lead_w, tail_w;
    assign disj_w = (rs_reg >= te_reg) || (re_reg <= ts_reg);
    assign gap_w  = (rs_reg >= te_reg) && (cur_reg < te_reg);
    assign lead_w = disj_w ? gap_w : ((rs_reg < ts_reg) || (rs_reg > cur_reg));
    assign tail_w = !disj_w && (re_reg > te_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_acc) state_next = (in_s >= in_e) ? S_RESULT : S_SCAN;
            S_SCAN:   if (eq_v_reg == 3'b0 && phase_reg == 1'b0 && idx_reg >= count_reg)
                          state_next = S_TAIL;
            S_TAIL:   state_next = S_COPY;
            S_COPY:   if (status_reg != ST_INSERTED ||
                          (idx_reg >= CW'(wn_reg) && phase_reg == 1'b0))
                          state_next = S_RESULT;
            S_RESULT: if (out_acc) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_RESULT);
        m_tdata  = {7'b0, 7'(count_reg), 16'(peak_reg), status_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            peak_reg  <= '0;
            eq_v_reg  <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: if (in_acc) begin
                    ts_reg <= in_s; te_reg <= in_e; td_reg <= in_d; cur_reg <= in_s;
                    idx_reg <= '0; wn_reg <= '0; phase_reg <= 1'b0; eq_v_reg <= '0;
                    eq_k_reg <= '0;
                    status_reg <= (in_s >= in_e) ? ST_EMPTY : ST_INSERTED;
                end
                S_SCAN: begin
                    if (eq_v_reg != 3'b0) begin
                        // drain the queue one slot at a time, writing out only the valid slots
                        if (eq_v_reg[eq_k_reg]) begin
                            if (wn_reg < WW'(CAPACITY)) begin
                                wrk_s_mem[wn_reg[AW-1:0]] <= eq_s_reg[eq_k_reg];
                                wrk_e_mem[wn_reg[AW-1:0]] <= eq_e_reg[eq_k_reg];
                                wrk_d_mem[wn_reg[AW-1:0]] <= eq_d_reg[eq_k_reg];
                            end
                            wn_reg <= wn_reg + 1'b1;
                            eq_v_reg[eq_k_reg] <= 1'b0;
                        end
                        eq_k_reg <= eq_k_reg + 1'b1;
                    end else if (phase_reg) begin
                        phase_reg <= 1'b0;
                        eq_k_reg  <= '0;
                        eq_v_reg  <= {tail_w, 1'b1, lead_w};
                        if (disj_w) begin
                            if (gap_w) begin
                                eq_s_reg[0] <= cur_reg; eq_e_reg[0] <= te_reg;
                                eq_d_reg[0] <= td_reg;
                                cur_reg <= te_reg;
                            end
                            eq_s_reg[1] <= rs_reg; eq_e_reg[1] <= re_reg; eq_d_reg[1] <= rd_reg;
                        end else begin
                            if (rs_reg < ts_reg) begin
                                eq_s_reg[0] <= rs_reg; eq_e_reg[0] <= ts_reg;
                                eq_d_reg[0] <= rd_reg;
                            end else if (rs_reg > cur_reg) begin
                                eq_s_reg[0] <= cur_reg; eq_e_reg[0] <= rs_reg;
                                eq_d_reg[0] <= td_reg;
                            end
                            eq_s_reg[1] <= (rs_reg > ts_reg) ? rs_reg : ts_reg;
                            eq_e_reg[1] <= (re_reg < te_reg) ? re_reg : te_reg;
                            eq_d_reg[1] <= sum_w[DB] ? DMAX : sum_w[DB-1:0];
                            cur_reg <= (re_reg < te_reg) ? re_reg : te_reg;
                            if (re_reg > te_reg) begin
                                eq_s_reg[2] <= te_reg; eq_e_reg[2] <= re_reg;
                                eq_d_reg[2] <= rd_reg;
                            end
                        end
                    end else if (idx_reg < count_reg) begin
                        rs_reg <= seg_s_mem[idx_reg[AW-1:0]];
                        re_reg <= seg_e_mem[idx_reg[AW-1:0]];
                        rd_reg <= seg_d_mem[idx_reg[AW-1:0]];
                        idx_reg <= idx_reg + 1'b1;
                        phase_reg <= 1'b1;
                    end
                end
                S_TAIL: begin
                    if (cur_reg < te_reg) begin
                        if (wn_reg < WW'(CAPACITY)) begin
                            wrk_s_mem[wn_reg[AW-1:0]] <= cur_reg;
                            wrk_e_mem[wn_reg[AW-1:0]] <= te_reg;
                            wrk_d_mem[wn_reg[AW-1:0]] <= td_reg;
                        end
                        if (wn_reg + 1'b1 > WW'(CAPACITY)) status_reg <= ST_FULL;
                        wn_reg <= wn_reg + 1'b1;
                    end else if (wn_reg > WW'(CAPACITY)) begin
                        status_reg <= ST_FULL;
                    end
                    idx_reg <= '0;
                    peak_acc_reg <= '0;
                end
                S_COPY: if (status_reg == ST_INSERTED) begin
                    // write back the entry fetched last cycle while fetching the next
                    if (phase_reg) begin
                        seg_s_mem[wa_reg] <= rs_reg;
                        seg_e_mem[wa_reg] <= re_reg;
                        seg_d_mem[wa_reg] <= rd_reg;
                        if (rd_reg > peak_acc_reg) peak_acc_reg <= rd_reg;
                    end
                    if (idx_reg < CW'(wn_reg)) begin
                        rs_reg <= wrk_s_mem[idx_reg[AW-1:0]];
                        re_reg <= wrk_e_mem[idx_reg[AW-1:0]];
                        rd_reg <= wrk_d_mem[idx_reg[AW-1:0]];
                        wa_reg <= idx_reg[AW-1:0];
                        idx_reg <= idx_reg + 1'b1;
                        phase_reg <= 1'b1;
                    end else if (phase_reg) begin
                        phase_reg <= 1'b0;
                    end else begin
                        count_reg <= CW'(wn_reg);
                        peak_reg  <= peak_acc_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY)) else $error("count beyond capacity");
    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY && status_reg != ST_INSERTED) |=> $stable(count_reg))
        else $error("dropped insert changed table");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result lost");
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for demand_profile_insert: drives task requests, predicts status, peak and count
// from a behavioral segment table, and checks every result in order. Depends on dpi_pkg.
`default_nettype none
module testbench;
    import dpi_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] peak;
        logic [6:0]  count;
    } profile_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    demand_profile_insert dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // behavioral copy of the segment table
    logic [31:0] seg_lo [CAP];
    logic [31:0] seg_hi [CAP];
    logic [15:0] seg_dem [CAP];
    int          seg_count = 0;
    logic [15:0] seg_peak = '0;

    profile_result_t pending_results [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  hold_receiver = 1'b0;
    bit  sink_bursty = 1'b1;
    int  send_gap_max = 3;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
        logic [16:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[16] ? 16'hFFFF : r[15:0];
    endfunction

    // apply one task to the table and return the status/peak/count it yields
    function automatic profile_result_t insert_task(logic [31:0] ts, logic [31:0] te,
                                                    logic [15:0] td);
        logic [31:0] nlo [2*CAP+3];
        logic [31:0] nhi [2*CAP+3];
        logic [15:0] ndem [2*CAP+3];
        int n;
        logic [31:0] cur, os, oe;
        logic [15:0] pk;
        profile_result_t r;
        n = 0;
        if (ts >= te) begin
            r.status = ST_EMPTY; r.peak = seg_peak; r.count = 7'(seg_count);
            return r;
        end
        cur = ts;
        for (int i = 0; i < seg_count; i++) begin
            if (seg_lo[i] >= te || seg_hi[i] <= ts) begin
                if (seg_lo[i] >= te && cur < te) begin
                    nlo[n] = cur; nhi[n] = te; ndem[n] = td; n++;
                    cur = te;
                end
                nlo[n] = seg_lo[i]; nhi[n] = seg_hi[i]; ndem[n] = seg_dem[i]; n++;
            end else begin
                os = (seg_lo[i] > ts) ? seg_lo[i] : ts;
                oe = (seg_hi[i] < te) ? seg_hi[i] : te;
                if (seg_lo[i] < ts) begin
                    nlo[n] = seg_lo[i]; nhi[n] = ts; ndem[n] = seg_dem[i]; n++;
                end else if (seg_lo[i] > cur) begin
                    nlo[n] = cur; nhi[n] = seg_lo[i]; ndem[n] = td; n++;
                end
                nlo[n] = os; nhi[n] = oe; ndem[n] = sat_sum(seg_dem[i], td); n++;
                cur = oe;
                if (seg_hi[i] > te) begin
                    nlo[n] = te; nhi[n] = seg_hi[i]; ndem[n] = seg_dem[i]; n++;
                end
            end
        end
        if (cur < te) begin
            nlo[n] = cur; nhi[n] = te; ndem[n] = td; n++;
        end
        if (n > CAP) begin
            r.status = ST_FULL; r.peak = seg_peak; r.count = 7'(seg_count);
            return r;
        end
        pk = '0;
        for (int i = 0; i < n; i++) begin
            seg_lo[i] = nlo[i]; seg_hi[i] = nhi[i]; seg_dem[i] = ndem[i];
            if (ndem[i] > pk) pk = ndem[i];
        end
        seg_count = n;
        seg_peak = pk;
        r.status = ST_INSERTED; r.peak = pk; r.count = 7'(n);
        return r;
    endfunction

    function automatic int short_or_long_gap(int max_short);
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, max_short);
    endfunction

    task automatic send_task(logic [31:0] ts, logic [31:0] te, logic [15:0] td);
        int gap;
        gap = (send_gap_max == 0) ? 0 : short_or_long_gap(send_gap_max);
        // always wait for a clock edge first, so tvalid is never driven twice in one step
        repeat (gap + 1) @(posedge aclk);
        s_tdata  <= {td, te, ts};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.insert(pending_results.size(), insert_task(ts, te, td));
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2 * CAP + 10) @(posedge aclk);
    endtask

    // clear the table by starting over from a fresh table state is not possible
    // without reset, so tests that need an empty-ish table fill distinct ranges

    task automatic test_directed();
        send_task(32'd10, 32'd10, 16'd5);            // empty span on empty table
        send_task(32'd20, 32'd5, 16'd5);             // reversed span
        send_task(32'd100, 32'd200, 16'd0);          // zero demand segment
        send_task(32'd150, 32'd250, 16'd7);          // split at start, gap at end
        send_task(32'd50, 32'd300, 16'd3);           // covers all with gaps both sides
        send_task(32'd120, 32'd130, 16'hFFFF);       // saturate inside
        send_task(32'd120, 32'd130, 16'hFFFF);       // saturate again
        send_task(32'd0, 32'd1, 16'hFFFF);           // lowest time
        send_task(32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h8001);
        send_task(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
        send_task(32'h0000_0001, 32'hFFFF_FFFF, 16'h5555);
        send_task(32'd125, 32'd126, 16'hAAAA);       // inside one segment: three-way split
        send_task(32'd0, 32'hFFFF_FFFF, 16'd1);
        drain_results();
    endtask

    // fill the table to capacity with narrow tasks, then trip the full case
    task automatic test_capacity();
        for (int i = 0; i < 70; i++)
            send_task(32'h4000_0000 + 32'(i * 4), 32'h4000_0000 + 32'(i * 4) + 32'd2,
                      16'(i));
        send_task(32'h4000_0001, 32'h4000_0100, 16'd9);
        drain_results();
    endtask

    // long receiver hold so the block stalls its input
    task automatic test_backpressure();
        hold_receiver <= 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_receiver <= 1'b0;
            end
            for (int i = 0; i < 4; i++)
                send_task($urandom, $urandom, 16'($urandom));
        join
        drain_results();
    endtask

    // random tasks; the table is full after capacity test, so most land on existing
    // boundaries or over full spans and mix inserted, full and empty outcomes
    task automatic test_random();
        logic [31:0] a, b;
        logic [15:0] d;
        int pick;
        for (int i = 0; i < 640; i++) begin
            pick = $urandom_range(0, 9);
            if (seg_count > 0 && pick < 5) begin
                a = seg_lo[$urandom_range(0, seg_count - 1)];
                b = seg_hi[$urandom_range(0, seg_count - 1)];
            end else if (pick < 8) begin
                a = 32'h4000_0000 + $urandom_range(0, 300);
                b = a + $urandom_range(0, 40);
            end else begin
                a = $urandom;
                b = $urandom;
            end
            d = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                            : 16'($urandom);
            if (i == 320) begin
                drain_results();
                send_gap_max = 0;
            end
            if (i == 480) send_gap_max = 3;
            send_task(a, b, d);
        end
        drain_results();
    endtask

    // result sink: random stalls plus the hold from the back-pressure test
    always @(posedge aclk) begin
        if (!aresetn || hold_receiver) m_tready <= 1'b0;
        else if (sink_bursty) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        profile_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = profile_result_t'({m_tdata[1:0], m_tdata[17:2], m_tdata[24:18]});
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[31:25] !== 7'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d peak %0d/%0d count %0d/%0d",
                                 want.status, got.status, want.peak, got.peak,
                                 want.count, got.count);
                end
            end
        end
    end

    // count cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity();
        test_backpressure();
        sink_bursty = 1'b0;
        test_random();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
